@@ sv/spcis_pkg.sv @@
// Package for the slack-priority CPU/I/O scheduler.
// Holds sizes, codes, record and payload types shared by the scheduler top, the queue engine and the testbench.
// Depends on nothing.
`default_nettype none
package spcis_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int TASK_ID_BITS = 10;
    localparam int QIDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_QUEUES   = 4;
    localparam int ADDR_W       = QIDX_W + 2;
    localparam int RAM_DEPTH    = NUM_QUEUES << QIDX_W;

    localparam logic [15:0] FINISH_THR_RST = 16'd15;
    localparam logic [15:0] FINISH_MAX     = 16'hFFFF;

    localparam logic [2:0] EV_TIMER   = 3'd0;
    localparam logic [2:0] EV_ARRIVAL = 3'd1;
    localparam logic [2:0] EV_FINISH  = 3'd2;
    localparam logic [2:0] EV_IO_REQ  = 3'd3;
    localparam logic [2:0] EV_IO_END  = 3'd4;

    typedef enum logic [1:0] {
        Q_CPU     = 2'd0,
        Q_IO      = 2'd1,
        Q_CPU_EXP = 2'd2,
        Q_IO_EXP  = 2'd3
    } t_qsel;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } t_op;

    typedef struct packed {
        logic [TASK_ID_BITS-1:0] id;
        logic [31:0]             deadline;
        logic [31:0]             slack;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic  valid;
        t_op   op;
        t_qsel q;
        t_rec  rec;
    } t_qcmd;

    typedef struct packed {
        logic                                done;
        t_rec                                rec;
        logic [NUM_QUEUES-1:0][CNT_W-1:0]    cnt;
    } t_qsts;

    typedef struct packed {
        logic [2:0]              event_kind;
        logic [31:0]             event_time;
        logic [TASK_ID_BITS-1:0] task_id;
        logic [31:0]             arrival_time;
        logic [31:0]             deadline_time;
        logic                    last_event;
        logic [TASK_ID_BITS-1:0] io_current;
    } t_evt;

    typedef struct packed {
        logic [TASK_ID_BITS-1:0] cpu_task;
        logic [TASK_ID_BITS-1:0] io_task;
    } t_res;

    typedef enum logic [2:0] {
        E_IDLE,
        E_PUSH_RD,
        E_PUSH_CMP,
        E_HEAD,
        E_POP_RD,
        E_POP_MV
    } t_estate;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WAIT,
        S_AFTER_EVT,
        S_PARK_PEEK,
        S_PARK_TEST,
        S_PARK_PUSH,
        S_PICK,
        S_GOT,
        S_NEXT,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

@@ sv/slack_priority_cpu_io_scheduler.sv @@
// Top level of the slack-priority CPU/I/O scheduler: event sequencer and config.
// Depends on spcis_pkg, spcis_qeng and spcis_ram.
//
// Usage:
// An event transfer happens at a rising edge with i_start high and o_busy low;
// the event fields travel in i_evt. Events without last_event produce no result.
// An event with last_event set produces one result on o_res, marked by
// o_res_valid for exactly one cycle; the receiver cannot stall it.
// The finish threshold is written on the config channel (i_cfg_valid with o_cfg_ready,
// which is always high); the user must write it only while the block is idle, as the block does not enforce it.
// Each queue is a sorted array in one shared RAM. A push walks from the tail,
// moving each entry with larger slack up one place; a pop or park step shifts the
// queue down by one entry. The work at a batch end grows with the number of
// entries moved and of tasks parked.
// After reset all queues are empty, the records are zero and the threshold
// is 15.
`default_nettype none
module slack_priority_cpu_io_scheduler (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    input  wire spcis_pkg::t_evt i_evt,
    output logic                 o_res_valid,
    output spcis_pkg::t_res      o_res,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [15:0]     i_cfg_data
);
    localparam int IDW = spcis_pkg::TASK_ID_BITS;

    spcis_pkg::t_state r_state, n_state;
    spcis_pkg::t_state r_ret, n_ret;
    logic              r_side, n_side;
    logic              r_last, n_last;
    logic [IDW-1:0]    r_io_cur, n_io_cur;
    logic [IDW-1:0]    r_cpu_pick, n_cpu_pick;
    logic [IDW-1:0]    r_io_pick, n_io_pick;
    spcis_pkg::t_rec   r_resp, n_resp;
    spcis_pkg::t_rec   r_cpu_rec, n_cpu_rec;
    spcis_pkg::t_rec   r_io_rec, n_io_rec;
    logic              r_cpu_busy, n_cpu_busy;
    logic              r_flag, n_flag;
    logic [15:0]       r_fin, n_fin;
    logic [31:0]       r_latest, n_latest;
    logic [15:0]       r_thr;

    spcis_pkg::t_qcmd  cmd;
    spcis_pkg::t_qsts  sts;
    spcis_pkg::t_rec   new_rec;
    spcis_pkg::t_qsel  live_q;
    spcis_pkg::t_qsel  exp_q;

    spcis_qeng u_qeng (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_sts  (sts)
    );

    assign new_rec.id       = i_evt.task_id;
    assign new_rec.deadline = i_evt.deadline_time;
    assign new_rec.slack    = i_evt.deadline_time - i_evt.arrival_time;
    assign live_q = r_side ? spcis_pkg::Q_IO : spcis_pkg::Q_CPU;
    assign exp_q  = r_side ? spcis_pkg::Q_IO_EXP : spcis_pkg::Q_CPU_EXP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= spcis_pkg::S_IDLE;
            r_ret      <= spcis_pkg::S_IDLE;
            r_cpu_rec  <= '0;
            r_io_rec   <= '0;
            r_cpu_busy <= 1'b0;
            r_flag     <= 1'b0;
            r_fin      <= '0;
            r_latest   <= '0;
            r_thr      <= spcis_pkg::FINISH_THR_RST;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_cpu_rec  <= n_cpu_rec;
            r_io_rec   <= n_io_rec;
            r_cpu_busy <= n_cpu_busy;
            r_flag     <= n_flag;
            r_fin      <= n_fin;
            r_latest   <= n_latest;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
        end
        r_side     <= n_side;
        r_last     <= n_last;
        r_io_cur   <= n_io_cur;
        r_cpu_pick <= n_cpu_pick;
        r_io_pick  <= n_io_pick;
        r_resp     <= n_resp;
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_side     = r_side;
        n_last     = r_last;
        n_io_cur   = r_io_cur;
        n_cpu_pick = r_cpu_pick;
        n_io_pick  = r_io_pick;
        n_resp     = r_resp;
        n_cpu_rec  = r_cpu_rec;
        n_io_rec   = r_io_rec;
        n_cpu_busy = r_cpu_busy;
        n_flag     = r_flag;
        n_fin      = r_fin;
        n_latest   = r_latest;
        cmd        = '0;
        unique case (r_state)
            spcis_pkg::S_IDLE: begin
                if (i_start) begin
                    n_latest   = i_evt.event_time;
                    n_last     = i_evt.last_event;
                    n_io_cur   = i_evt.io_current;
                    n_io_pick  = i_evt.io_current;
                    n_cpu_pick = '0;
                    n_ret      = spcis_pkg::S_AFTER_EVT;
                    n_state    = spcis_pkg::S_AFTER_EVT;
                    priority case (i_evt.event_kind)
                        spcis_pkg::EV_ARRIVAL: begin
                            cmd     = '{1'b1, spcis_pkg::OP_PUSH, spcis_pkg::Q_CPU, new_rec};
                            n_state = spcis_pkg::S_WAIT;
                        end
                        spcis_pkg::EV_FINISH: begin
                            n_flag = 1'b1;
                            if (r_fin != spcis_pkg::FINISH_MAX) begin
                                n_fin = r_fin + 1'b1;
                            end
                        end
                        spcis_pkg::EV_IO_REQ: begin
                            n_flag  = 1'b1;
                            cmd     = '{1'b1, spcis_pkg::OP_PUSH, spcis_pkg::Q_IO, r_cpu_rec};
                            n_state = spcis_pkg::S_WAIT;
                        end
                        spcis_pkg::EV_IO_END: begin
                            cmd     = '{1'b1, spcis_pkg::OP_PUSH, spcis_pkg::Q_CPU, r_io_rec};
                            n_state = spcis_pkg::S_WAIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            spcis_pkg::S_WAIT: begin
                if (sts.done) begin
                    n_resp  = sts.rec;
                    n_state = r_ret;
                end
            end
            spcis_pkg::S_AFTER_EVT: begin
                if (!r_last) begin
                    n_state = spcis_pkg::S_IDLE;
                end else begin
                    n_side = 1'b0;
                    n_flag = 1'b0;
                    if (!r_flag && r_cpu_busy) begin
                        cmd     = '{1'b1, spcis_pkg::OP_PUSH, spcis_pkg::Q_CPU, r_cpu_rec};
                        n_ret   = spcis_pkg::S_PARK_PEEK;
                        n_state = spcis_pkg::S_WAIT;
                    end else begin
                        n_cpu_busy = 1'b0;
                        n_state    = spcis_pkg::S_PARK_PEEK;
                    end
                end
            end
            spcis_pkg::S_PARK_PEEK: begin
                if (sts.cnt[live_q] == '0) begin
                    n_state = spcis_pkg::S_PICK;
                end else begin
                    cmd     = '{1'b1, spcis_pkg::OP_PEEK, live_q, r_cpu_rec};
                    n_ret   = spcis_pkg::S_PARK_TEST;
                    n_state = spcis_pkg::S_WAIT;
                end
            end
            spcis_pkg::S_PARK_TEST: begin
                if (r_resp.deadline <= r_latest) begin
                    cmd     = '{1'b1, spcis_pkg::OP_POP, live_q, r_cpu_rec};
                    n_ret   = spcis_pkg::S_PARK_PUSH;
                    n_state = spcis_pkg::S_WAIT;
                end else begin
                    n_state = spcis_pkg::S_PICK;
                end
            end
            spcis_pkg::S_PARK_PUSH: begin
                cmd     = '{1'b1, spcis_pkg::OP_PUSH, exp_q, r_resp};
                n_ret   = spcis_pkg::S_PARK_PEEK;
                n_state = spcis_pkg::S_WAIT;
            end
            spcis_pkg::S_PICK: begin
                n_ret   = spcis_pkg::S_GOT;
                n_state = spcis_pkg::S_NEXT;
                if (!r_side || r_io_cur == '0) begin
                    if (sts.cnt[live_q] != '0) begin
                        cmd     = '{1'b1, spcis_pkg::OP_POP, live_q, r_cpu_rec};
                        n_state = spcis_pkg::S_WAIT;
                    end else if (sts.cnt[exp_q] != '0 && (!r_side || r_fin >= r_thr)) begin
                        cmd     = '{1'b1, spcis_pkg::OP_POP, exp_q, r_cpu_rec};
                        n_state = spcis_pkg::S_WAIT;
                    end
                end
            end
            spcis_pkg::S_GOT: begin
                if (!r_side) begin
                    n_cpu_rec  = r_resp;
                    n_cpu_pick = r_resp.id;
                    n_cpu_busy = 1'b1;
                end else begin
                    n_io_rec  = r_resp;
                    n_io_pick = r_resp.id;
                end
                n_state = spcis_pkg::S_NEXT;
            end
            spcis_pkg::S_NEXT: begin
                if (!r_side) begin
                    n_side  = 1'b1;
                    n_state = spcis_pkg::S_PARK_PEEK;
                end else begin
                    n_state = spcis_pkg::S_OUT;
                end
            end
            spcis_pkg::S_OUT: begin
                n_state = spcis_pkg::S_IDLE;
            end
            default: begin
                n_state = spcis_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy        = (r_state != spcis_pkg::S_IDLE);
    assign o_res_valid   = (r_state == spcis_pkg::S_OUT);
    assign o_res.cpu_task = r_cpu_pick;
    assign o_res.io_task  = r_io_pick;
    assign o_cfg_ready   = 1'b1;

    a_res_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted event did not make the block busy");
    a_res_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_last)
        else $error("result for an event that did not end a batch");
    a_wait_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.valid |-> r_state != spcis_pkg::S_WAIT)
        else $error("queue command issued while waiting");
endmodule
`default_nettype wire

@@ sv/spcis_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the queue store of the scheduler. No dependencies.
`default_nettype none
module spcis_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/spcis_qeng.sv @@
// Queue engine: four slack-sorted queues kept in one RAM, with push, pop and peek.
// Depends on spcis_pkg and spcis_ram.
`default_nettype none
module spcis_qeng (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire spcis_pkg::t_qcmd i_cmd,
    output spcis_pkg::t_qsts      o_sts
);
    spcis_pkg::t_estate r_state, n_state;
    spcis_pkg::t_op     r_op, n_op;
    spcis_pkg::t_qsel   r_q, n_q;
    spcis_pkg::t_rec    r_rec, n_rec;
    spcis_pkg::t_rec    r_resp, n_resp;
    logic [spcis_pkg::CNT_W-1:0] r_pos, n_pos;
    logic [spcis_pkg::NUM_QUEUES-1:0][spcis_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic r_done, n_done;

    logic                         we;
    logic [spcis_pkg::ADDR_W-1:0] waddr;
    logic [spcis_pkg::ADDR_W-1:0] raddr;
    logic [spcis_pkg::REC_W-1:0]  wdata;
    logic [spcis_pkg::REC_W-1:0]  rdata;
    spcis_pkg::t_rec              rd_rec;
    logic [spcis_pkg::CNT_W-1:0]  pos_m1;

    assign rd_rec = spcis_pkg::t_rec'(rdata);
    assign pos_m1 = r_pos - 1'b1;

    spcis_ram #(
        .W(spcis_pkg::REC_W),
        .D(spcis_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spcis_pkg::E_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        r_op   <= n_op;
        r_q    <= n_q;
        r_rec  <= n_rec;
        r_resp <= n_resp;
        r_pos  <= n_pos;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_q     = r_q;
        n_rec   = r_rec;
        n_resp  = r_resp;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        we      = 1'b0;
        waddr   = {r_q, r_pos[spcis_pkg::QIDX_W-1:0]};
        wdata   = r_rec;
        raddr   = {r_q, r_pos[spcis_pkg::QIDX_W-1:0]};
        unique case (r_state)
            spcis_pkg::E_IDLE: begin
                raddr = {i_cmd.q, {spcis_pkg::QIDX_W{1'b0}}};
                if (i_cmd.valid) begin
                    n_op  = i_cmd.op;
                    n_q   = i_cmd.q;
                    n_rec = i_cmd.rec;
                    if (i_cmd.op == spcis_pkg::OP_PUSH) begin
                        if (r_cnt[i_cmd.q] >= spcis_pkg::CNT_W'(spcis_pkg::QUEUE_DEPTH)) begin
                            n_done = 1'b1;
                        end else begin
                            n_pos   = r_cnt[i_cmd.q];
                            n_state = spcis_pkg::E_PUSH_RD;
                        end
                    end else begin
                        n_state = spcis_pkg::E_HEAD;
                    end
                end
            end
            spcis_pkg::E_PUSH_RD: begin
                raddr = {r_q, pos_m1[spcis_pkg::QIDX_W-1:0]};
                if (r_pos == '0) begin
                    we         = 1'b1;
                    n_cnt[r_q] = r_cnt[r_q] + 1'b1;
                    n_done     = 1'b1;
                    n_state    = spcis_pkg::E_IDLE;
                end else begin
                    n_state = spcis_pkg::E_PUSH_CMP;
                end
            end
            spcis_pkg::E_PUSH_CMP: begin
                we = 1'b1;
                if ($signed(r_rec.slack) < $signed(rd_rec.slack)) begin
                    wdata   = rdata;
                    n_pos   = pos_m1;
                    n_state = spcis_pkg::E_PUSH_RD;
                end else begin
                    n_cnt[r_q] = r_cnt[r_q] + 1'b1;
                    n_done     = 1'b1;
                    n_state    = spcis_pkg::E_IDLE;
                end
            end
            spcis_pkg::E_HEAD: begin
                n_resp = rd_rec;
                if (r_op == spcis_pkg::OP_PEEK) begin
                    n_done  = 1'b1;
                    n_state = spcis_pkg::E_IDLE;
                end else begin
                    n_pos   = spcis_pkg::CNT_W'(1);
                    n_state = spcis_pkg::E_POP_RD;
                end
            end
            spcis_pkg::E_POP_RD: begin
                if (r_pos >= r_cnt[r_q]) begin
                    n_cnt[r_q] = r_cnt[r_q] - 1'b1;
                    n_done     = 1'b1;
                    n_state    = spcis_pkg::E_IDLE;
                end else begin
                    n_state = spcis_pkg::E_POP_MV;
                end
            end
            spcis_pkg::E_POP_MV: begin
                we      = 1'b1;
                waddr   = {r_q, pos_m1[spcis_pkg::QIDX_W-1:0]};
                wdata   = rdata;
                n_pos   = r_pos + 1'b1;
                n_state = spcis_pkg::E_POP_RD;
            end
            default: begin
                n_state = spcis_pkg::E_IDLE;
            end
        endcase
    end

    assign o_sts.done = r_done;
    assign o_sts.rec  = r_resp;
    assign o_sts.cnt  = r_cnt;

    localparam logic [spcis_pkg::CNT_W-1:0] DEPTH_C = spcis_pkg::CNT_W'(spcis_pkg::QUEUE_DEPTH);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= DEPTH_C && r_cnt[1] <= DEPTH_C && r_cnt[2] <= DEPTH_C && r_cnt[3] <= DEPTH_C)
        else $error("queue count above depth");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == spcis_pkg::E_IDLE)
        else $error("done while engine still working");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == spcis_pkg::E_POP_RD && r_pos >= r_cnt[r_q] |-> r_cnt[r_q] != '0)
        else $error("pop from empty queue");
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for slack_priority_cpu_io_scheduler.
// Depends on spcis_pkg and the scheduler RTL; predicts every decision with its own
// queue model and checks each result transfer against it.
`default_nettype none
module tb_top;

    localparam logic [2:0] EV_SPARE_LO = 3'd5;
    localparam logic [2:0] EV_SPARE_HI = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              o_busy;
    spcis_pkg::t_evt   i_evt = '0;
    logic              o_res_valid;
    spcis_pkg::t_res   o_res;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [15:0]       i_cfg_data = '0;

    slack_priority_cpu_io_scheduler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_evt      (i_evt),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Scheduler state as predicted.
    spcis_pkg::t_rec   task_q[4][$];
    spcis_pkg::t_rec   run_cpu;
    spcis_pkg::t_rec   run_io;
    bit                cpu_busy;
    bit                finish_seen;
    logic [15:0]       done_cnt;
    logic [31:0]       now_stamp;
    logic [15:0]       finish_thr;

    spcis_pkg::t_res   pending_picks[$];
    int                err_cnt;
    int                evt_cnt;
    int                pick_cnt;
    bit                gaps_on;
    logic [31:0]       clock_base;

    function automatic void queue_insert(int k, spcis_pkg::t_rec r);
        int pos;
        if (task_q[k].size() >= spcis_pkg::QUEUE_DEPTH) return;
        pos = task_q[k].size();
        while (pos > 0 && $signed(r.slack) < $signed(task_q[k][pos-1].slack)) pos--;
        task_q[k].insert(pos, r);
    endfunction

    function automatic void park_late(int live, int late);
        while (task_q[live].size() > 0 && task_q[live][0].deadline <= now_stamp)
            queue_insert(late, task_q[live].pop_front());
    endfunction

    function automatic void schedule_event(spcis_pkg::t_evt e);
        spcis_pkg::t_rec r;
        spcis_pkg::t_res d;
        now_stamp = e.event_time;
        case (e.event_kind)
            spcis_pkg::EV_ARRIVAL: begin
                r.id = e.task_id;
                r.deadline = e.deadline_time;
                r.slack = e.deadline_time - e.arrival_time;
                queue_insert(spcis_pkg::Q_CPU, r);
            end
            spcis_pkg::EV_FINISH: begin
                finish_seen = 1'b1;
                if (done_cnt != spcis_pkg::FINISH_MAX) done_cnt++;
            end
            spcis_pkg::EV_IO_REQ: begin
                finish_seen = 1'b1;
                queue_insert(spcis_pkg::Q_IO, run_cpu);
            end
            spcis_pkg::EV_IO_END: queue_insert(spcis_pkg::Q_CPU, run_io);
            default: ;
        endcase
        if (!e.last_event) return;
        if (!finish_seen && cpu_busy) queue_insert(spcis_pkg::Q_CPU, run_cpu);
        else cpu_busy = 1'b0;
        finish_seen = 1'b0;
        d.cpu_task = '0;
        d.io_task = e.io_current;
        park_late(spcis_pkg::Q_CPU, spcis_pkg::Q_CPU_EXP);
        if (task_q[spcis_pkg::Q_CPU].size() > 0) begin
            run_cpu = task_q[spcis_pkg::Q_CPU].pop_front();
            d.cpu_task = run_cpu.id;
            cpu_busy = 1'b1;
        end else if (task_q[spcis_pkg::Q_CPU_EXP].size() > 0) begin
            run_cpu = task_q[spcis_pkg::Q_CPU_EXP].pop_front();
            d.cpu_task = run_cpu.id;
            cpu_busy = 1'b1;
        end
        park_late(spcis_pkg::Q_IO, spcis_pkg::Q_IO_EXP);
        if (e.io_current == '0) begin
            if (task_q[spcis_pkg::Q_IO].size() > 0) begin
                run_io = task_q[spcis_pkg::Q_IO].pop_front();
                d.io_task = run_io.id;
            end else if (task_q[spcis_pkg::Q_IO_EXP].size() > 0 && done_cnt >= finish_thr) begin
                run_io = task_q[spcis_pkg::Q_IO_EXP].pop_front();
                d.io_task = run_io.id;
            end
        end
        pending_picks.push_back(d);
    endfunction

    task automatic send_event(spcis_pkg::t_evt e);
        if (gaps_on) begin
            while ($urandom_range(99) < 38) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_evt <= e;
        do @(posedge i_clk); while (o_busy);
        schedule_event(e);
        evt_cnt++;
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_picks.size() != 0 || o_busy) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [15:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        finish_thr = v;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic spcis_pkg::t_evt make_event(logic [2:0] kind, logic last);
        spcis_pkg::t_evt e;
        logic [31:0] dl;
        clock_base += $urandom_range(0, 20);
        e.event_kind = kind;
        e.event_time = ($urandom_range(29) == 0) ? $urandom : clock_base;
        e.task_id = 10'($urandom_range(0, 1023));
        dl = clock_base + $urandom_range(0, 300) - 60;
        e.deadline_time = ($urandom_range(29) == 0) ? $urandom : dl;
        e.arrival_time = ($urandom_range(29) == 0) ? $urandom : dl - $urandom_range(0, 500);
        e.last_event = last;
        e.io_current = ($urandom_range(2) == 0) ? 10'($urandom_range(1, 1023)) : '0;
        return e;
    endfunction

    function automatic spcis_pkg::t_evt arrival(logic [9:0] id, logic [31:0] tnow,
                                                logic [31:0] arr, logic [31:0] dl,
                                                logic last, logic [9:0] io_cur);
        spcis_pkg::t_evt e;
        e.event_kind = spcis_pkg::EV_ARRIVAL;
        e.event_time = tnow;
        e.task_id = id;
        e.arrival_time = arr;
        e.deadline_time = dl;
        e.last_event = last;
        e.io_current = io_cur;
        return e;
    endfunction

    task automatic test_directed();
        spcis_pkg::t_evt e;
        send_event(make_event(spcis_pkg::EV_TIMER, 1'b1));
        send_event(arrival(10'd0, 32'd0, 32'd0, 32'd100, 1'b0, 10'd0));
        send_event(arrival(10'd1023, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 10'd0));
        send_event(arrival(10'd5, 32'd10, 32'd10, 32'd60, 1'b0, 10'd0));
        send_event(arrival(10'd6, 32'd10, 32'd20, 32'd70, 1'b0, 10'd0));
        send_event(arrival(10'd7, 32'd10, 32'd0, 32'h8000_0000, 1'b1, 10'd1023));
        e = make_event(spcis_pkg::EV_IO_REQ, 1'b0);
        send_event(e);
        e = make_event(spcis_pkg::EV_FINISH, 1'b1);
        e.io_current = '0;
        send_event(e);
        e = make_event(spcis_pkg::EV_IO_END, 1'b1);
        e.io_current = '0;
        send_event(e);
        for (int k = EV_SPARE_LO; k <= EV_SPARE_HI; k++)
            send_event(make_event(3'(k), 1'(k == EV_SPARE_HI)));
        // Tasks already past deadline get parked before the pick.
        send_event(arrival(10'd40, 32'd500, 32'd0, 32'd100, 1'b0, 10'd0));
        send_event(arrival(10'd41, 32'd500, 32'd0, 32'd900, 1'b1, 10'd0));
        send_event(arrival(10'd42, 32'hFFFF_FFFF, 32'd5, 32'd0, 1'b1, 10'd0));
        e = make_event(spcis_pkg::EV_IO_REQ, 1'b1);
        e.event_time = 32'hFFFF_FFFF;
        e.io_current = '0;
        send_event(e);
        send_event(make_event(spcis_pkg::EV_TIMER, 1'b1));
    endtask

    task automatic test_full_queue();
        for (int n = 0; n < 70; n++) send_event(make_event(spcis_pkg::EV_ARRIVAL, 1'b0));
        for (int n = 0; n < 72; n++) send_event(make_event(spcis_pkg::EV_IO_REQ, 1'b0));
        for (int n = 0; n < 75; n++) send_event(make_event(spcis_pkg::EV_FINISH, 1'b1));
    endtask

    task automatic test_random(int count);
        int pick;
        logic [2:0] kind;
        for (int n = 0; n < count; n++) begin
            gaps_on = (n > count / 5);
            pick = $urandom_range(99);
            if (pick < 35) kind = spcis_pkg::EV_ARRIVAL;
            else if (pick < 50) kind = spcis_pkg::EV_FINISH;
            else if (pick < 68) kind = spcis_pkg::EV_IO_REQ;
            else if (pick < 82) kind = spcis_pkg::EV_IO_END;
            else if (pick < 95) kind = spcis_pkg::EV_TIMER;
            else kind = 3'($urandom_range(EV_SPARE_LO, EV_SPARE_HI));
            send_event(make_event(kind, $urandom_range(99) < 40));
        end
    endtask

    task automatic test_thresholds();
        set_threshold(16'd0);
        test_random(150);
        set_threshold(16'hFFFF);
        test_random(150);
        set_threshold(16'($urandom_range(1, 300)));
        test_random(150);
        set_threshold(spcis_pkg::FINISH_THR_RST);
    endtask

    always @(posedge i_clk) begin
        spcis_pkg::t_res want;
        if (i_rst_n && o_res_valid) begin
            pick_cnt++;
            if (pending_picks.size() == 0) begin
                $display("%0t: unexpected result cpu=%0d io=%0d", $time,
                         o_res.cpu_task, o_res.io_task);
                err_cnt++;
            end else begin
                want = pending_picks.pop_front();
                if (o_res.cpu_task !== want.cpu_task) begin
                    $display("%0t: cpu_task expected %0d got %0d", $time,
                             want.cpu_task, o_res.cpu_task);
                    err_cnt++;
                end
                if (o_res.io_task !== want.io_task) begin
                    $display("%0t: io_task expected %0d got %0d", $time,
                             want.io_task, o_res.io_task);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        run_cpu = '0;
        run_io = '0;
        cpu_busy = 1'b0;
        finish_seen = 1'b0;
        done_cnt = '0;
        now_stamp = '0;
        finish_thr = spcis_pkg::FINISH_THR_RST;
        err_cnt = 0;
        evt_cnt = 0;
        pick_cnt = 0;
        gaps_on = 1'b1;
        clock_base = 32'd1000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_thresholds();
        test_full_queue();
        test_random(1500);
        drain();
        if (pending_picks.size() != 0) err_cnt++;
        $display("Sent %0d events and checked %0d decisions, including full queues,", evt_cnt,
                 pick_cnt);
        $display("parking of late tasks and threshold settings 0, 65535 and others.");
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/spcis_pkg.sv
sv/spcis_ram.sv
sv/spcis_qeng.sv
sv/slack_priority_cpu_io_scheduler.sv
verif/tb_top.sv
